[hw/rtl/bmhq_pkg.sv]
// Shared types and constants for the binary min-heap priority queue.
// No dependencies; bmhq_if, bmhq_sift, binary_min_heap_queue and bmhq_chk use this package.
`default_nettype none

package bmhq_pkg;

    // Default sizes of the heap store and the entry fields
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int KEY_WIDTH_DEF  = 32;

    // Operation carried by a request
    typedef enum logic
    {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    // Outcome reported with every result
    typedef enum logic [1:0]
    {
        ST_DONE       = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } status_t;

    // Sequencer states of the sift engine
    typedef enum logic [2:0]
    {
        S_IDLE,
        S_UP,
        S_DN_LAST,
        S_DN,
        S_PLACE,
        S_FIN
    } state_t;

    // Completion report from the sift engine to the output stage
    typedef struct packed
    {
        logic    done;
        status_t status;
    } result_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/bmhq_if.sv]
// Request and response channel interfaces of the min-heap queue.
// Depends on bmhq_pkg for default field widths.
`default_nettype none

interface bmhq_req_if #(
    parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF,
    parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [DATA_WIDTH-1:0] item_data;
    logic [KEY_WIDTH-1:0]  item_key;

    modport source (output valid, output mode, output item_data, output item_key,
                    input ready);
    modport sink   (input valid, input mode, input item_data, input item_key,
                    output ready);
endinterface

interface bmhq_rsp_if #(
    parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF,
    parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF,
    parameter int CNT_WIDTH  = $clog2(bmhq_pkg::DEPTH_DEF + 1)
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] top_data;
    logic [KEY_WIDTH-1:0]  top_key;
    logic                  is_empty;
    logic [CNT_WIDTH-1:0]  entry_count;
    logic [1:0]            status;

    modport source (output valid, output top_data, output top_key, output is_empty,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input top_data, input top_key, input is_empty,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/bmhq_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

[hw/rtl/bmhq_sift.sv]
// Sift engine: fill count, root shadow and the push/pop sequencer over the heap RAM.
// Depends on bmhq_pkg; drives the ports of one bmhq_ram instance.
`default_nettype none

module bmhq_sift #(
    parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF,
    parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int EW        = DATA_WIDTH + KEY_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request side
    input  wire logic                  req_fire,
    input  wire logic                  req_mode,
    input  wire logic [DATA_WIDTH-1:0] req_data,
    input  wire logic [KEY_WIDTH-1:0]  req_key,
    output logic                       idle,
    // result side
    input  wire logic                  res_take,
    output bmhq_pkg::result_ctl_t      res,
    output logic      [DATA_WIDTH-1:0] top_data,
    output logic      [KEY_WIDTH-1:0]  top_key,
    output logic      [CW-1:0]         count,
    // heap RAM port
    output logic                       mem_we,
    output logic      [AW-1:0]         mem_waddr,
    output logic      [EW-1:0]         mem_wdata,
    output logic      [AW-1:0]         mem_raddr_a,
    output logic      [AW-1:0]         mem_raddr_b,
    input  wire logic [EW-1:0]         mem_rdata_a,
    input  wire logic [EW-1:0]         mem_rdata_b
);
    import bmhq_pkg::*;

    localparam int PW = CW + 1;

    state_t          state_reg,  state_next;
    status_t         status_reg, status_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic [AW-1:0]   pos_reg,    pos_next;
    logic [EW-1:0]   item_reg,   item_next;
    logic [EW-1:0]   top_reg,    top_next;

    logic [EW-1:0]   req_item;
    logic [AW-1:0]   up_parent;
    logic [AW-1:0]   up_grand;
    logic [AW-1:0]   cnt_m1_a;
    logic [AW-1:0]   cnt_parent;
    logic [PW-1:0]   pos_w;
    logic [PW-1:0]   left_pos;
    logic [PW-1:0]   right_pos;
    logic [PW-1:0]   size_w;
    logic            right_ok;
    logic            pick_right;
    logic [EW-1:0]   pick_ent;
    logic [PW-1:0]   pick_pos;
    logic [PW-1:0]   next_left;
    logic [PW-1:0]   next_right;

    // Address arithmetic for both sift directions
    always_comb
    begin
        req_item   = {req_data, req_key};
        cnt_m1_a   = count_reg[AW-1:0] - AW'(1);
        cnt_parent = cnt_m1_a >> 1;
        up_parent  = (pos_reg - AW'(1)) >> 1;
        up_grand   = (up_parent - AW'(1)) >> 1;
        pos_w      = PW'(pos_reg);
        size_w     = PW'(count_reg);
        left_pos   = (pos_w << 1) + PW'(1);
        right_pos  = left_pos + PW'(1);
        right_ok   = right_pos < size_w;
        pick_right = right_ok
                     && !(mem_rdata_a[KEY_WIDTH-1:0] < mem_rdata_b[KEY_WIDTH-1:0]);
        pick_ent   = pick_right ? mem_rdata_b : mem_rdata_a;
        pick_pos   = pick_right ? right_pos : left_pos;
        next_left  = (pick_pos << 1) + PW'(1);
        next_right = next_left + PW'(1);
    end

    // Control registers: state, fill count and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Payload, position and root shadow registers
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        item_reg <= item_next;
        top_reg  <= top_next;
    end

    // Sequencer: one heap level per cycle, the hole moves while the item rides in item_reg
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        top_next    = top_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = item_reg;
        mem_raddr_a = '0;
        mem_raddr_b = '0;
        res.done    = 1'b0;
        res.status  = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    item_next   = req_item;
                    status_next = ST_DONE;
                    if (mode_t'(req_mode) == MODE_PUSH)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            // drop push on full heap
                            status_next = ST_PUSH_FULL;
                            state_next  = S_FIN;
                        end
                        else if (count_reg == '0)
                        begin
                            // first entry becomes the root directly
                            count_next = count_reg + CW'(1);
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = req_item;
                            top_next   = req_item;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            count_next  = count_reg + CW'(1);
                            pos_next    = count_reg[AW-1:0];
                            mem_raddr_a = cnt_parent;
                            state_next  = S_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            // ignore pop on empty heap
                            status_next = ST_POP_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (count_reg == CW'(1))
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                // fetch the last entry
                                mem_raddr_a = cnt_m1_a;
                                state_next  = S_DN_LAST;
                            end
                        end
                    end
                end
            end

            S_UP:
            begin
                mem_we = 1'b1;
                if (item_reg[KEY_WIDTH-1:0] < mem_rdata_a[KEY_WIDTH-1:0])
                begin
                    // move parent down into the hole
                    mem_wdata = mem_rdata_a;
                    pos_next  = up_parent;
                    if (up_parent == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_raddr_a = up_grand;
                    end
                end
                else
                begin
                    // settle item below a parent that is not larger
                    state_next = S_FIN;
                end
            end

            S_DN_LAST:
            begin
                item_next = mem_rdata_a;
                pos_next  = '0;
                if (count_reg == CW'(1))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = mem_rdata_a;
                    top_next   = mem_rdata_a;
                    state_next = S_FIN;
                end
                else
                begin
                    mem_raddr_a = AW'(1);
                    mem_raddr_b = AW'(2);
                    state_next  = S_DN;
                end
            end

            S_DN:
            begin
                mem_we = 1'b1;
                if (pick_ent[KEY_WIDTH-1:0] < item_reg[KEY_WIDTH-1:0])
                begin
                    // lift the smaller child into the hole
                    mem_wdata = pick_ent;
                    if (pos_reg == '0)
                    begin
                        top_next = pick_ent;
                    end
                    pos_next = pick_pos[AW-1:0];
                    if (next_left < size_w)
                    begin
                        mem_raddr_a = next_left[AW-1:0];
                        mem_raddr_b = next_right[AW-1:0];
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    if (pos_reg == '0)
                    begin
                        top_next = item_reg;
                    end
                    state_next = S_FIN;
                end
            end

            S_PLACE:
            begin
                mem_we = 1'b1;
                if (pos_reg == '0)
                begin
                    top_next = item_reg;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                res.done = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Report idle, the fill count and the root, zero when the heap is empty
    always_comb
    begin
        idle  = (state_reg == S_IDLE);
        count = count_reg;
        if (count_reg == '0)
        begin
            top_data = '0;
            top_key  = '0;
        end
        else
        begin
            top_data = top_reg[EW-1:KEY_WIDTH];
            top_key  = top_reg[KEY_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/binary_min_heap_queue.sv]
// Binary min-heap priority queue of (data, key) pairs.
// Channels: req (sink) takes mode, item_data, item_key; rsp (source) returns one
//   result per request: top_data, top_key, is_empty, entry_count, status.
// A push appends the pair and sifts it up; a pop moves the last entry to the root
//   and sifts it down. A pop on an empty heap and a push on a full heap leave the
//   heap unchanged and report that in status.
// A result enters the output register from S_FIN, which the sequencer reaches directly
//   when no heap entry is read (pop on empty, push on full, first push, last pop),
//   and through the sift states for a full sift. The sift visits one heap level per
//   cycle: each level is one registered read of the heap RAM followed by one compare
//   and write-back.
// Requests are taken one at a time; req.ready is high only while the sequencer
//   is idle, so a new request is accepted only after the last result leaves S_FIN.
// A finished result waits in the output register; the next request is accepted
//   meanwhile, and its result is held in the sequencer until rsp takes the earlier one.
// Reset clears the fill count and the control state; the heap RAM needs no clearing,
//   since only entries below the fill count are used. No clearing pass is run.
// Depends on bmhq_pkg, bmhq_if, bmhq_ram and bmhq_sift.
`default_nettype none

module binary_min_heap_queue #(
    parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF,
    parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmhq_req_if.sink    req,
    bmhq_rsp_if.source  rsp
);
    import bmhq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = DATA_WIDTH + KEY_WIDTH;

    logic                  idle;
    logic                  req_fire;
    logic                  res_take;
    result_ctl_t           res;
    logic [DATA_WIDTH-1:0] sift_top_data;
    logic [KEY_WIDTH-1:0]  sift_top_key;
    logic [CW-1:0]         sift_count;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [EW-1:0]         mem_rdata_a;
    logic [EW-1:0]         mem_rdata_b;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [KEY_WIDTH-1:0]  out_key_reg;
    logic [CW-1:0]         out_count_reg;
    status_t               out_status_reg;

    assign req.ready = idle;
    assign req_fire  = req.valid && idle;
    assign res_take  = !out_valid_reg || rsp.ready;

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    bmhq_sift #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_sift (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_fire    (req_fire),
        .req_mode    (req.mode),
        .req_data    (req.item_data),
        .req_key     (req.item_key),
        .idle        (idle),
        .res_take    (res_take),
        .res         (res),
        .top_data    (sift_top_data),
        .top_key     (sift_top_key),
        .count       (sift_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    // Output valid: set on a result transfer in, clear when rsp takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.done && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (res.done && res_take)
        begin
            out_data_reg   <= sift_top_data;
            out_key_reg    <= sift_top_key;
            out_count_reg  <= sift_count;
            out_status_reg <= res.status;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.top_data    = out_data_reg;
    assign rsp.top_key     = out_key_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.is_empty    = (out_count_reg == '0);
    assign rsp.status      = out_status_reg;

endmodule

`default_nettype wire

[hw/rtl/bmhq_chk.sv]
// Port-level checker for binary_min_heap_queue, attached by the bind below.
// Depends on bmhq_pkg for status codes.
`default_nettype none

module bmhq_chk #(
    parameter int DEPTH      = bmhq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEF,
    parameter int KEY_WIDTH  = bmhq_pkg::KEY_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  req_valid,
    input wire logic                  req_ready,
    input wire logic                  rsp_valid,
    input wire logic                  rsp_ready,
    input wire logic [DATA_WIDTH-1:0] rsp_top_data,
    input wire logic [KEY_WIDTH-1:0]  rsp_top_key,
    input wire logic                  rsp_is_empty,
    input wire logic [CW-1:0]         rsp_entry_count,
    input wire logic [1:0]            rsp_status
);
    import bmhq_pkg::*;

    // Stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count)
            && $stable(rsp_top_key) && $stable(rsp_top_data) && $stable(rsp_status))
        else $error("stalled result changed");

    // One request in flight: ready drops after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while sift busy");

    // Empty flag matches the count, and an empty heap shows a zero root
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0))
            && (!rsp_is_empty || (rsp_top_key == '0 && rsp_top_data == '0)))
        else $error("empty flag inconsistent");

    // Dropped push only on a full heap, ignored pop only on an empty one, count never above DEPTH
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status != ST_PUSH_FULL || rsp_entry_count == CW'(DEPTH))
            && (rsp_status != ST_POP_EMPTY || rsp_is_empty)
            && rsp_entry_count <= CW'(DEPTH))
        else $error("status inconsistent with count");

endmodule

bind binary_min_heap_queue bmhq_chk #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .KEY_WIDTH  (KEY_WIDTH)
) u_bmhq_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_top_data    (rsp.top_data),
    .rsp_top_key     (rsp.top_key),
    .rsp_is_empty    (rsp.is_empty),
    .rsp_entry_count (rsp.entry_count),
    .rsp_status      (rsp.status)
);

`default_nettype wire
